// ----- rtl/swrm_pkg.sv -----
`default_nettype none

package swrm_pkg;

	// Operation codes of an input item
	localparam logic [1:0] OP_XFER  = 2'd0;
	localparam logic [1:0] OP_PROBE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Buckets in each direction's ring
	localparam int unsigned NUM_BKT = 3;

	// Classified item, as held in the queue between front and back
	typedef struct packed {
		logic        is_xfer;
		logic        is_probe;
		logic        is_clear;
		logic        dir;
		logic [31:0] now;
		logic [19:0] bytes;
	} item_t;

	// Direction state after one item, handed to the sum and average pipeline
	typedef struct packed {
		logic [NUM_BKT-1:0][31:0] bkt;
		logic [31:0]              tot;
		logic [31:0]              act;
	} snap_t;

	// Advance a ring pointer, wrapping after the last bucket
	function automatic logic [1:0] ptr_next(input logic [1:0] p);
		logic [1:0] r;
		r = (p >= 2'(NUM_BKT - 1)) ? 2'd0 : p + 2'd1;
		return r;
	endfunction

	// One radix-16 step of a long division by three: {quotient nibble, remainder}.
	// v is below 48, so v*43/128 gives floor(v/3) exactly.
	function automatic logic [5:0] div3_step(input logic [1:0] rem, input logic [3:0] nib);
		logic [5:0]  v;
		logic [10:0] prod;
		logic [3:0]  q;
		logic [5:0]  r;
		v    = {rem, nib};
		prod = 11'(v) * 11'd43;
		q    = prod[10:7];
		r    = v - 6'(q) * 6'd3;
		return {q, r[1:0]};
	endfunction

endpackage

`default_nettype wire

// ----- rtl/swrm_front.sv -----
`default_nettype none

module swrm_front import swrm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic        direction,
	input  wire logic [31:0] now_seconds,
	input  wire logic [19:0] byte_count,
	input  wire logic        pop,
	output logic             q_valid,
	output item_t            q_item
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;
	logic       do_pop;

	// Classify the incoming item
	always_comb begin
		cls          = '0;
		cls.dir      = direction;
		cls.now      = now_seconds;
		cls.bytes    = byte_count;
		unique case (operation)
			OP_XFER:  cls.is_xfer  = 1'b1;
			OP_PROBE: cls.is_probe = 1'b1;
			OP_CLEAR: cls.is_clear = 1'b1;
			default:  cls.is_xfer  = 1'b0;
		endcase
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign do_pop   = pop && q_valid;
	assign q_item   = slot_q[rd_ptr_q];

	// Hold classified items until the back end takes them
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	// Advance queue pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/swrm_ring.sv -----
`default_nettype none

module swrm_ring import swrm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  q_valid,
	input  wire item_t q_item,
	output logic       valid_s1,
	output snap_t      snap_s1
);

	logic [NUM_BKT-1:0][31:0] bkt_q [2];
	logic [1:0]               ptr_q [2];
	logic [31:0]              chg_q [2];
	logic [31:0]              tot_q [2];
	logic [31:0]              act_q;

	logic                     take;
	logic                     d;
	logic [NUM_BKT-1:0][31:0] cur;
	logic [NUM_BKT-1:0][31:0] nb;
	logic [1:0]               p;
	logic [1:0]               p1;
	logic [1:0]               p2;
	logic [1:0]               np;
	logic [31:0]              step;
	logic [31:0]              val;
	logic [31:0]              cur_p;
	logic [32:0]              sum_p;
	logic [31:0]              sat_p;
	logic                     upd;
	snap_t                    snap;

	assign take = adv && q_valid;
	assign d    = q_item.dir;
	assign cur  = bkt_q[d];
	assign p    = ptr_q[d];
	assign p1   = ptr_next(p);
	assign p2   = ptr_next(p1);
	assign step = q_item.now - chg_q[d];
	assign val  = q_item.is_xfer ? 32'(q_item.bytes) : 32'd0;
	assign upd  = q_item.is_xfer || q_item.is_probe;

	// Saturating add into the current bucket; a pointer past the ring reads zero
	always_comb begin
		cur_p = '0;
		for (int i = 0; i < NUM_BKT; i++) begin
			if (p == 2'(i)) begin
				cur_p = cur[i];
			end
		end
		sum_p = {1'b0, cur_p} + 33'(q_item.bytes);
		sat_p = sum_p[32] ? 32'hFFFF_FFFF : sum_p[31:0];
	end

	// Move the ring by the time step and write the item's value
	always_comb begin
		nb = cur;
		np = p;
		if (step == 32'd0) begin
			if (q_item.is_xfer) begin
				for (int i = 0; i < NUM_BKT; i++) begin
					if (p == 2'(i)) begin
						nb[i] = sat_p;
					end
				end
			end
		end else if (step == 32'd1) begin
			np = p1;
			for (int i = 0; i < NUM_BKT; i++) begin
				if (p1 == 2'(i)) begin
					nb[i] = val;
				end
			end
		end else if (step == 32'd2) begin
			np = p2;
			for (int i = 0; i < NUM_BKT; i++) begin
				if (p1 == 2'(i)) begin
					nb[i] = '0;
				end
				if (p2 == 2'(i)) begin
					nb[i] = val;
				end
			end
		end else begin
			nb = '0;
			for (int i = 0; i < NUM_BKT; i++) begin
				if (p == 2'(i)) begin
					nb[i] = val;
				end
			end
		end
	end

	// Form the direction's view after this item
	always_comb begin
		if (q_item.is_clear) begin
			snap = '0;
		end else begin
			snap.bkt = upd ? nb : cur;
			snap.tot = tot_q[d] + (q_item.is_xfer ? 32'(q_item.bytes) : 32'd0);
			snap.act = q_item.is_xfer ? q_item.now : act_q;
		end
	end

	// Commit direction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				bkt_q[k] <= '0;
				ptr_q[k] <= '0;
				chg_q[k] <= '0;
				tot_q[k] <= '0;
			end
			act_q <= '0;
		end else if (take) begin
			if (q_item.is_clear) begin
				for (int k = 0; k < 2; k++) begin
					bkt_q[k] <= '0;
					ptr_q[k] <= '0;
					chg_q[k] <= '0;
					tot_q[k] <= '0;
				end
				act_q <= '0;
			end else if (upd) begin
				bkt_q[d] <= nb;
				ptr_q[d] <= np;
				chg_q[d] <= q_item.now;
				if (q_item.is_xfer) begin
					tot_q[d] <= snap.tot;
					act_q    <= q_item.now;
				end
			end
		end
	end

	// Advance stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid;
		end
	end

	// Capture snapshot
	always_ff @(posedge clk) begin
		if (take) begin
			snap_s1 <= snap;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/swrm_avg.sv -----
`default_nettype none

module swrm_avg import swrm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  valid_s1,
	input  wire snap_t snap_s1,
	output logic       out_valid,
	output logic [33:0] window_sum,
	output logic [39:0] average_rate_q8,
	output logic [31:0] direction_total,
	output logic [31:0] last_activity_time
);

	logic        valid_s2;
	logic        valid_s3;
	logic        valid_s4;
	logic        out_valid_q;
	logic [33:0] sum_s2;
	logic [33:0] sum_s3;
	logic [33:0] sum_s4;
	logic [31:0] tot_s2;
	logic [31:0] tot_s3;
	logic [31:0] tot_s4;
	logic [31:0] act_s2;
	logic [31:0] act_s3;
	logic [31:0] act_s4;
	logic [15:0] quo_s3;
	logic [1:0]  rem_s3;
	logic [27:0] low_s3;
	logic [31:0] quo_s4;
	logic [1:0]  rem_s4;
	logic [11:0] low_s4;
	logic [33:0] sum_q;
	logic [39:0] avg_q;
	logic [31:0] tot_q;
	logic [31:0] act_q;

	logic [43:0] dvd;
	logic [15:0] quo_a;
	logic [1:0]  rem_a;
	logic [15:0] quo_b;
	logic [1:0]  rem_b;
	logic [11:0] quo_c;
	logic [1:0]  rem_c;
	logic [43:0] quo_full;

	// Long division of sum*256 by three, four nibbles in the first two stages
	// and three in the last
	assign dvd = {2'b00, sum_s2, 8'h00};

	always_comb begin
		logic [5:0] r;
		rem_a = '0;
		quo_a = '0;
		for (int j = 0; j < 4; j++) begin
			r = div3_step(rem_a, dvd[43 - 4*j -: 4]);
			quo_a[15 - 4*j -: 4] = r[5:2];
			rem_a = r[1:0];
		end
	end

	always_comb begin
		logic [5:0] r;
		rem_b = rem_s3;
		quo_b = '0;
		for (int j = 0; j < 4; j++) begin
			r = div3_step(rem_b, low_s3[27 - 4*j -: 4]);
			quo_b[15 - 4*j -: 4] = r[5:2];
			rem_b = r[1:0];
		end
	end

	always_comb begin
		logic [5:0] r;
		rem_c = rem_s4;
		quo_c = '0;
		for (int j = 0; j < 3; j++) begin
			r = div3_step(rem_c, low_s4[11 - 4*j -: 4]);
			quo_c[11 - 4*j -: 4] = r[5:2];
			rem_c = r[1:0];
		end
	end

	assign quo_full = {quo_s4, quo_c};

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

	// Advance payload: sum, division stages, output register
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2 <= 34'(snap_s1.bkt[0]) + 34'(snap_s1.bkt[1]) + 34'(snap_s1.bkt[2]);
			tot_s2 <= snap_s1.tot;
			act_s2 <= snap_s1.act;

			sum_s3 <= sum_s2;
			tot_s3 <= tot_s2;
			act_s3 <= act_s2;
			quo_s3 <= quo_a;
			rem_s3 <= rem_a;
			low_s3 <= dvd[27:0];

			sum_s4 <= sum_s3;
			tot_s4 <= tot_s3;
			act_s4 <= act_s3;
			quo_s4 <= {quo_s3, quo_b};
			rem_s4 <= rem_b;
			low_s4 <= low_s3[11:0];

			sum_q <= sum_s4;
			avg_q <= quo_full[39:0];
			tot_q <= tot_s4;
			act_q <= act_s4;
		end
	end

	assign out_valid          = out_valid_q;
	assign window_sum         = sum_q;
	assign average_rate_q8    = avg_q;
	assign direction_total    = tot_q;
	assign last_activity_time = act_q;

endmodule

`default_nettype wire

// ----- rtl/sliding_window_rate_meter.sv -----
// Channel  Handshake            Payload
// -------  -------------------  ---------------------------------------------------
// input    in_valid / in_ready  operation, direction, now_seconds, byte_count
// output   out_valid/out_ready  window_sum, average_rate_q8, direction_total,
//                               last_activity_time
//
// One item per cycle sustained while the output side does not stall; each item yields
// one result after the queue, ring, sum, division and output registers.
// The ring stage updates a direction's buckets in the cycle an item leaves the
// two-entry queue, so consecutive items on the same direction follow at once.
// arst_n clears all buckets, pointers, times and totals and empties the pipeline.
// A stalled output freezes the back pipeline; the queue keeps taking items until
// it holds two.
`default_nettype none

module sliding_window_rate_meter import swrm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic        direction,
	input  wire logic [31:0] now_seconds,
	input  wire logic [19:0] byte_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [33:0]      window_sum,
	output logic [39:0]      average_rate_q8,
	output logic [31:0]      direction_total,
	output logic [31:0]      last_activity_time
);

	logic  adv;
	logic  q_valid;
	item_t q_item;
	logic  valid_s1;
	snap_t snap_s1;

	// Move the back pipeline whenever the output register is empty or its result is taken
	assign adv = !out_valid || out_ready;

	swrm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.direction   (direction),
		.now_seconds (now_seconds),
		.byte_count  (byte_count),
		.pop         (adv),
		.q_valid     (q_valid),
		.q_item      (q_item)
	);

	swrm_ring u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.valid_s1 (valid_s1),
		.snap_s1  (snap_s1)
	);

	swrm_avg u_avg (
		.clk                (clk),
		.arst_n             (arst_n),
		.adv                (adv),
		.valid_s1           (valid_s1),
		.snap_s1            (snap_s1),
		.out_valid          (out_valid),
		.window_sum         (window_sum),
		.average_rate_q8    (average_rate_q8),
		.direction_total    (direction_total),
		.last_activity_time (last_activity_time)
	);

`ifndef SYNTH
	// Average times three must not exceed sum*256
	a_avg_low: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (44'(average_rate_q8) * 44'd3 <= 44'({window_sum, 8'h00})))
		else $error("average above sum/3");

	// Sum*256 must be below (average+1) times three
	a_avg_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (44'({window_sum, 8'h00}) < 44'(average_rate_q8) * 44'd3 + 44'd3))
		else $error("average below sum/3");

	// Three saturated buckets bound the window sum
	a_sum_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (window_sum <= 34'h2_FFFF_FFFD))
		else $error("window sum beyond three full buckets");
`endif

endmodule

`default_nettype wire

// ----- bench/rate_meter_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rate_meter_checker import swrm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic        direction,
	input  wire logic [31:0] now_seconds,
	input  wire logic [19:0] byte_count,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [33:0] window_sum,
	input  wire logic [39:0] average_rate_q8,
	input  wire logic [31:0] direction_total,
	input  wire logic [31:0] last_activity_time,
	output int unsigned      mismatches,
	output int unsigned      readings_waiting,
	output int unsigned      readings_checked
);

	typedef struct packed {
		logic [33:0] sum;
		logic [39:0] avg;
		logic [31:0] tot;
		logic [31:0] act;
	} reading_t;

	// Mirror of the meter state, reset values
	logic [31:0] bucket [2][3];
	logic [1:0]  ring_ptr [2];
	logic [31:0] changed_at [2];
	logic [31:0] total [2];
	logic [31:0] last_xfer;

	reading_t expected_readings [$];

	initial begin
		clear_meter();
		mismatches       = 0;
		readings_waiting = 0;
		readings_checked = 0;
	end

	task automatic clear_meter();
		for (int d = 0; d < 2; d++) begin
			for (int i = 0; i < 3; i++)
				bucket[d][i] = '0;
			ring_ptr[d]   = '0;
			changed_at[d] = '0;
			total[d]      = '0;
		end
		last_xfer = '0;
	endtask

	function automatic logic [1:0] ring_advance(input logic [1:0] p);
		return (p == 2'd2) ? 2'd0 : p + 2'd1;
	endfunction

	// Move the ring of one direction to time t and write val into the new bucket
	task automatic move_ring(input logic d, input logic [31:0] t, input logic [31:0] val,
			input logic add);
		logic [31:0] step;
		logic [1:0]  p;
		logic [32:0] s;
		step = t - changed_at[d];
		p    = ring_ptr[d];
		if (step == 32'd0) begin
			// same second: accumulate, saturate at the top of the bucket
			if (add) begin
				s = {1'b0, bucket[d][p]} + {1'b0, val};
				bucket[d][p] = s[32] ? 32'hFFFF_FFFF : s[31:0];
			end
		end else if (step == 32'd1 || step == 32'd2) begin
			if (step == 32'd2) begin
				p = ring_advance(p);
				bucket[d][p] = '0;
			end
			p = ring_advance(p);
			bucket[d][p] = val;
		end else begin
			// gap or backward step: drop the whole window
			for (int i = 0; i < 3; i++)
				bucket[d][i] = '0;
			bucket[d][p] = val;
		end
		ring_ptr[d]   = p;
		changed_at[d] = t;
	endtask

	// Apply one item and queue the reading it should produce
	task automatic meter_update(input logic [1:0] op, input logic d, input logic [31:0] t,
			input logic [19:0] n);
		reading_t    r;
		logic [41:0] scaled;
		case (op)
			OP_XFER: begin
				move_ring(d, t, {12'd0, n}, 1'b1);
				total[d]  = total[d] + {12'd0, n};
				last_xfer = t;
			end
			OP_PROBE: move_ring(d, t, 32'd0, 1'b0);
			OP_CLEAR: clear_meter();
			default: ;
		endcase
		r.sum  = 34'(bucket[d][0]) + 34'(bucket[d][1]) + 34'(bucket[d][2]);
		scaled = {r.sum, 8'd0};
		r.avg  = 40'(scaled / 42'd3);
		r.tot  = total[d];
		r.act  = last_xfer;
		expected_readings.push_back(r);
	endtask

	// Predict on accepted items, compare accepted results against the oldest reading
	always @(posedge clk) begin
		reading_t r;
		if (arst_n) begin
			if (in_valid && in_ready)
				meter_update(operation, direction, now_seconds, byte_count);
			if (out_valid && out_ready) begin
				if (expected_readings.size() == 0) begin
					$error("result with no reading expected: sum %0d total %0d",
						window_sum, direction_total);
					mismatches++;
				end else begin
					r = expected_readings.pop_front();
					readings_checked++;
					if (window_sum !== r.sum) begin
						$error("window_sum: expected %0d, got %0d", r.sum, window_sum);
						mismatches++;
					end
					if (average_rate_q8 !== r.avg) begin
						$error("average_rate_q8: expected %0d, got %0d", r.avg,
							average_rate_q8);
						mismatches++;
					end
					if (direction_total !== r.tot) begin
						$error("direction_total: expected %0d, got %0d", r.tot,
							direction_total);
						mismatches++;
					end
					if (last_activity_time !== r.act) begin
						$error("last_activity_time: expected %0d, got %0d", r.act,
							last_activity_time);
						mismatches++;
					end
				end
			end
			readings_waiting = expected_readings.size();
		end
	end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import swrm_pkg::*;

	// Unassigned operation code, must leave the state alone
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned BURST_ITEMS = 30;
	localparam int unsigned RANDOM_ITEMS = 1596;

	typedef struct packed {
		logic [1:0]  op;
		logic        dir;
		logic [31:0] t;
		logic [19:0] n;
	} item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic        direction;
	logic [31:0] now_seconds;
	logic [19:0] byte_count;
	logic        out_valid;
	logic        out_ready;
	logic [33:0] window_sum;
	logic [39:0] average_rate_q8;
	logic [31:0] direction_total;
	logic [31:0] last_activity_time;

	int unsigned mismatches;
	int unsigned readings_waiting;
	int unsigned readings_checked;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;
	logic        steady = 1'b0;
	logic        hold_req = 1'b0;
	logic        hold_done;
	logic [31:0] dir_clock [2];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	sliding_window_rate_meter uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.direction(direction),
		.now_seconds(now_seconds),
		.byte_count(byte_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.window_sum(window_sum),
		.average_rate_q8(average_rate_q8),
		.direction_total(direction_total),
		.last_activity_time(last_activity_time)
	);

	rate_meter_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.direction(direction),
		.now_seconds(now_seconds),
		.byte_count(byte_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.window_sum(window_sum),
		.average_rate_q8(average_rate_q8),
		.direction_total(direction_total),
		.last_activity_time(last_activity_time),
		.mismatches(mismatches),
		.readings_waiting(readings_waiting),
		.readings_checked(readings_checked)
	);

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sliding_window_rate_meter test failed");
			$finish;
		end
	end

	// Result side: random back-pressure, one long hold when asked
	initial begin
		out_ready = 1'b0;
		hold_done = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (80) @(negedge clk);
				hold_done = 1'b1;
			end
			out_ready <= steady || ($urandom_range(0, 99) >= 9);
		end
	end

	// Offer one item and hold it until accepted
	task automatic send_item(input logic [1:0] op, input logic dir, input logic [31:0] t,
			input logic [19:0] n);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		direction   <= dir;
		now_seconds <= t;
		byte_count  <= n;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Stop offering and wait for every outstanding reading
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (readings_waiting != 0) @(negedge clk);
	endtask

	// Mostly plausible time steps per direction, with some gaps, rewinds and jumps
	task automatic random_item();
		int unsigned pick;
		logic [1:0]  op;
		logic        d;
		logic [31:0] t;
		logic [19:0] n;
		d    = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 62)
			op = OP_XFER;
		else if (pick < 92)
			op = OP_PROBE;
		else if (pick < 96)
			op = OP_CLEAR;
		else
			op = OP_SPARE;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			t = dir_clock[d];
		else if (pick < 65)
			t = dir_clock[d] + 32'd1;
		else if (pick < 82)
			t = dir_clock[d] + 32'd2;
		else if (pick < 88)
			t = dir_clock[d] + 32'd3;
		else if (pick < 94)
			t = dir_clock[d] - 32'($urandom_range(1, 3));
		else
			t = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			n = 20'hFFFFF;
		else if (pick < 40)
			n = 20'($urandom_range(0, 15));
		else
			n = 20'($urandom);
		if (op == OP_XFER || op == OP_PROBE)
			dir_clock[d] = t;
		else if (op == OP_CLEAR && $urandom_range(0, 1) == 1) begin
			dir_clock[0] = 32'($urandom_range(0, 2));
			dir_clock[1] = 32'($urandom_range(0, 2));
		end
		send_item(op, d, t, n);
	endtask

	initial begin
		item_t opening [20];

		opening = '{
			'{OP_XFER,  1'b0, 32'd0,          20'hFFFFF},
			'{OP_XFER,  1'b0, 32'd0,          20'd5},
			'{OP_XFER,  1'b0, 32'd1,          20'd7},
			'{OP_XFER,  1'b0, 32'd3,          20'd9},
			'{OP_PROBE, 1'b0, 32'd3,          20'hFFFFF},
			'{OP_PROBE, 1'b0, 32'd4,          20'd0},
			'{OP_PROBE, 1'b0, 32'd6,          20'd1},
			'{OP_XFER,  1'b0, 32'd10,         20'd100},
			'{OP_XFER,  1'b0, 32'd9,          20'd3},
			'{OP_XFER,  1'b1, 32'hFFFF_FFFF,  20'hAAAAA},
			'{OP_XFER,  1'b1, 32'd0,          20'h55555},
			'{OP_XFER,  1'b1, 32'd2,          20'd1},
			'{OP_PROBE, 1'b1, 32'd3,          20'd0},
			'{OP_SPARE, 1'b1, 32'd12345,      20'hFFFFF},
			'{OP_SPARE, 1'b0, 32'hFFFF_FFFF,  20'd0},
			'{OP_XFER,  1'b0, 32'h8000_0000,  20'd1},
			'{OP_CLEAR, 1'b1, 32'hFFFF_FFFF,  20'hFFFFF},
			'{OP_PROBE, 1'b0, 32'd0,          20'd0},
			'{OP_XFER,  1'b1, 32'h7FFF_FFFF,  20'hFFFFF},
			'{OP_XFER,  1'b1, 32'h8000_0001,  20'h12345}
		};

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		operation   = OP_XFER;
		direction   = 1'b0;
		now_seconds = '0;
		byte_count  = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: ring steps, wrap-around time, rewinds, clear, spare code
		foreach (opening[i])
			send_item(opening[i].op, opening[i].dir, opening[i].t, opening[i].n);
		drain();

		// Back-to-back full transfers in one second, then ring steps after them
		steady = 1'b1;
		send_item(OP_CLEAR, 1'b0, 32'd0, 20'd0);
		for (int i = 0; i < BURST_ITEMS; i++)
			send_item(OP_XFER, 1'b0, 32'd500, 20'hFFFFF);
		send_item(OP_PROBE, 1'b0, 32'd501, 20'd0);
		send_item(OP_XFER, 1'b0, 32'd502, 20'd9);
		send_item(OP_PROBE, 1'b0, 32'd503, 20'd0);
		steady = 1'b0;
		drain();

		// Random traffic, one long result stall and one stretch with no idling
		dir_clock[0] = 32'hFFFF_FFF0;
		dir_clock[1] = $urandom;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 400)
				hold_req = 1'b1;
			steady = (i >= 900 && i < 1100);
			random_item();
		end
		steady = 1'b0;
		drain();
		repeat (24) @(negedge clk);

		$display("covered %0d items and %0d results: ring steps, rewinds, clears,",
			items_sent, readings_checked);
		$display("same-second bursts, time wrap-around and stalls on both sides");
		if (mismatches == 0)
			$display("sliding_window_rate_meter test passed");
		else
			$display("sliding_window_rate_meter test failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/swrm_pkg.sv
rtl/swrm_front.sv
rtl/swrm_ring.sv
rtl/swrm_avg.sv
rtl/sliding_window_rate_meter.sv
bench/rate_meter_checker.sv
bench/testbench.sv
